### design/v3alu_pkg.sv
// ----------------------------------------------------------------------------
// v3alu_pkg
// Shared types and opcodes of the three-component fixed-point vector ALU.
// ----------------------------------------------------------------------------
package v3alu_pkg;

    localparam int unsigned FIX_W = 32;
    localparam int unsigned OP_W  = 3;

    typedef logic signed [FIX_W-1:0] fix_t;
    typedef logic [FIX_W-1:0]        mag_t;
    typedef logic [OP_W-1:0]         op_t;

    localparam op_t OP_ADD    = 3'd0;
    localparam op_t OP_SUB    = 3'd1;
    localparam op_t OP_SCALE  = 3'd2;
    localparam op_t OP_CROSS  = 3'd3;
    localparam op_t OP_NORM   = 3'd4;
    localparam op_t OP_NSCALE = 3'd5;

    typedef struct packed {
        op_t        op;
        fix_t [2:0] res;
        logic       sat;
        logic       zero;
        logic [2:0] neg;
        fix_t       factor;
    } side_t;

endpackage

### design/vec3_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// vec3_fixed_point_alu
// Pipelined vector ALU on signed fixed point: add, subtract, scale, cross,
// normalize and normalize-then-scale, with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel in_valid/in_ready carries op, vectors a and b and factor.
//   Result channel out_valid/out_ready carries rx, ry, rz, zero_length and
//   saturated. Every request yields exactly one result, in request order.
//   Throughput is one request per cycle unless the receiver stalls. The
//   pipeline holds 43 + FRAC_BITS register stages: six front stages (input,
//   products, leading-zero search, saturation, operand scaling, squares), a
//   sum stage, a 32-stage square-root pipeline, a FRAC_BITS + 2 stage
//   restoring divider with one lane per component, a multiply stage and a
//   round stage into the output register. All operations travel the same
//   depth, so results stay in order.
//   When the receiver stalls, the whole pipeline holds; in_ready equals
//   !out_valid || out_ready, so nothing is dropped or repeated.
//   Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module vec3_fixed_point_alu #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  v3alu_pkg::op_t    op,
    input  v3alu_pkg::fix_t   ax,
    input  v3alu_pkg::fix_t   ay,
    input  v3alu_pkg::fix_t   az,
    input  v3alu_pkg::fix_t   bx,
    input  v3alu_pkg::fix_t   by,
    input  v3alu_pkg::fix_t   bz,
    input  v3alu_pkg::fix_t   factor,
    output logic              out_valid,
    input  logic              out_ready,
    output v3alu_pkg::fix_t   rx,
    output v3alu_pkg::fix_t   ry,
    output v3alu_pkg::fix_t   rz,
    output logic              zero_length,
    output logic              saturated
);

    localparam int unsigned SQ_STEPS  = 32;
    localparam int unsigned NUM_W     = 33 + FRAC_BITS;
    localparam int unsigned Q_W       = FRAC_BITS + 1;
    localparam int unsigned DIV_STEPS = FRAC_BITS + 1;

    localparam logic signed [65:0] RND66  = 66'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [63:0] RND64  = 64'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [65:0] SMAX66 = 66'sd2147483647;
    localparam logic signed [65:0] SMIN66 = -66'sd2147483648;
    localparam logic signed [63:0] SMAX64 = 64'sd2147483647;
    localparam logic signed [63:0] SMIN64 = -64'sd2147483648;
    localparam v3alu_pkg::fix_t    FMAX   = 32'sh7fffffff;
    localparam v3alu_pkg::fix_t    FMIN   = 32'sh80000000;

    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // ------------------------------------------------------------------ S1
    logic            s1_vld_reg;
    v3alu_pkg::op_t  s1_op_reg;
    v3alu_pkg::fix_t s1_a_reg [3];
    v3alu_pkg::fix_t s1_b_reg [3];
    v3alu_pkg::fix_t s1_f_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg   <= op;
            s1_a_reg[0] <= ax;
            s1_a_reg[1] <= ay;
            s1_a_reg[2] <= az;
            s1_b_reg[0] <= bx;
            s1_b_reg[1] <= by;
            s1_b_reg[2] <= bz;
            s1_f_reg    <= factor;
        end
    end

    // ------------------------------------------------------------------ S2
    logic               s2_vld_reg;
    v3alu_pkg::op_t     s2_op_reg;
    v3alu_pkg::mag_t    s2_mag_reg [3];
    v3alu_pkg::mag_t    s2_max_reg;
    logic signed [63:0] s2_prod_reg [6];
    logic signed [32:0] s2_lin_reg [3];
    logic [2:0]         s2_neg_reg;
    v3alu_pkg::fix_t    s2_f_reg;

    v3alu_pkg::mag_t    s2_mag_next [3];
    v3alu_pkg::mag_t    s2_max_next;
    logic signed [63:0] s2_prod_next [6];
    logic signed [32:0] s2_lin_next [3];

    always_comb
    begin
        v3alu_pkg::fix_t ma [6];
        v3alu_pkg::fix_t mb [6];
        for (int i = 0; i < 3; i++)
        begin
            s2_mag_next[i] = s1_a_reg[i][31] ? (~v3alu_pkg::mag_t'(s1_a_reg[i])) + 32'd1
                                             : v3alu_pkg::mag_t'(s1_a_reg[i]);
        end
        s2_max_next = s2_mag_next[0];
        if (s2_mag_next[1] > s2_max_next)
        begin
            s2_max_next = s2_mag_next[1];
        end
        if (s2_mag_next[2] > s2_max_next)
        begin
            s2_max_next = s2_mag_next[2];
        end
        for (int i = 0; i < 3; i++)
        begin
            case (s1_op_reg)
                v3alu_pkg::OP_ADD:
                    s2_lin_next[i] = {s1_a_reg[i][31], s1_a_reg[i]}
                                   + {s1_b_reg[i][31], s1_b_reg[i]};
                v3alu_pkg::OP_SUB:
                    s2_lin_next[i] = {s1_a_reg[i][31], s1_a_reg[i]}
                                   - {s1_b_reg[i][31], s1_b_reg[i]};
                default:
                    s2_lin_next[i] = {s1_a_reg[i][31], s1_a_reg[i]};
            endcase
        end
        ma[0] = s1_a_reg[1]; mb[0] = s1_b_reg[2];
        ma[1] = s1_a_reg[2]; mb[1] = s1_b_reg[1];
        ma[2] = s1_a_reg[2]; mb[2] = s1_b_reg[0];
        ma[3] = s1_a_reg[0]; mb[3] = s1_b_reg[2];
        ma[4] = s1_a_reg[0]; mb[4] = s1_b_reg[1];
        ma[5] = s1_a_reg[1]; mb[5] = s1_b_reg[0];
        if (s1_op_reg == v3alu_pkg::OP_SCALE)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ma[2*i]   = s1_a_reg[i];
                mb[2*i]   = s1_f_reg;
                ma[2*i+1] = '0;
                mb[2*i+1] = '0;
            end
        end
        for (int k = 0; k < 6; k++)
        begin
            s2_prod_next[k] = ma[k] * mb[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_op_reg  <= s1_op_reg;
            s2_max_reg <= s2_max_next;
            s2_f_reg   <= s1_f_reg;
            for (int i = 0; i < 3; i++)
            begin
                s2_mag_reg[i] <= s2_mag_next[i];
                s2_lin_reg[i] <= s2_lin_next[i];
                s2_neg_reg[i] <= s1_a_reg[i][31];
            end
            for (int k = 0; k < 6; k++)
            begin
                s2_prod_reg[k] <= s2_prod_next[k];
            end
        end
    end

    // ------------------------------------------------------------------ S3
    logic               s3_vld_reg;
    v3alu_pkg::op_t     s3_op_reg;
    logic signed [65:0] s3_pre_reg [3];
    logic [3:0]         s3_nz_reg;
    logic [2:0]         s3_lz_reg [4];
    v3alu_pkg::mag_t    s3_mag_reg [3];
    logic               s3_zero_reg;
    logic [2:0]         s3_neg_reg;
    v3alu_pkg::fix_t    s3_f_reg;

    logic signed [65:0] s3_pre_next [3];
    logic [3:0]         s3_nz_next;
    logic [2:0]         s3_lz_next [4];

    always_comb
    begin
        logic signed [65:0] diff;
        logic [7:0]         byte_v;
        for (int i = 0; i < 3; i++)
        begin
            diff = s2_prod_reg[2*i] - s2_prod_reg[2*i+1];
            case (s2_op_reg) inside
                v3alu_pkg::OP_SCALE, v3alu_pkg::OP_CROSS:
                    s3_pre_next[i] = (diff + RND66) >>> FRAC_BITS;
                default:
                    s3_pre_next[i] = s2_lin_reg[i];
            endcase
        end
        for (int k = 0; k < 4; k++)
        begin
            byte_v        = s2_max_reg[8*k +: 8];
            s3_nz_next[k] = |byte_v;
            s3_lz_next[k] = 3'd0;
            for (int b = 0; b < 8; b++)
            begin
                if (byte_v[b])
                begin
                    s3_lz_next[k] = 3'(7 - b);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_op_reg   <= s2_op_reg;
            s3_nz_reg   <= s3_nz_next;
            s3_zero_reg <= (s2_max_reg == '0);
            s3_neg_reg  <= s2_neg_reg;
            s3_f_reg    <= s2_f_reg;
            for (int i = 0; i < 3; i++)
            begin
                s3_pre_reg[i] <= s3_pre_next[i];
                s3_mag_reg[i] <= s2_mag_reg[i];
            end
            for (int k = 0; k < 4; k++)
            begin
                s3_lz_reg[k] <= s3_lz_next[k];
            end
        end
    end

    // ------------------------------------------------------------------ S4
    logic             s4_vld_reg;
    v3alu_pkg::side_t s4_side_reg;
    v3alu_pkg::mag_t  s4_mag_reg [3];
    logic [4:0]       s4_sh_reg;

    v3alu_pkg::side_t s4_side_next;
    logic [4:0]       s4_sh_next;

    always_comb
    begin
        logic [4:0] top_lz;
        s4_side_next.op     = s3_op_reg;
        s4_side_next.sat    = 1'b0;
        s4_side_next.zero   = s3_zero_reg;
        s4_side_next.neg    = s3_neg_reg;
        s4_side_next.factor = s3_f_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (s3_pre_reg[i] > SMAX66)
            begin
                s4_side_next.res[i] = FMAX;
                s4_side_next.sat    = 1'b1;
            end
            else if (s3_pre_reg[i] < SMIN66)
            begin
                s4_side_next.res[i] = FMIN;
                s4_side_next.sat    = 1'b1;
            end
            else
            begin
                s4_side_next.res[i] = s3_pre_reg[i][31:0];
            end
        end
        top_lz = 5'd31;
        for (int k = 0; k < 4; k++)
        begin
            if (s3_nz_reg[k])
            begin
                top_lz = 5'(8 * (3 - k)) + {2'b00, s3_lz_reg[k]};
            end
        end
        s4_sh_next = (top_lz == 5'd0) ? 5'd0 : top_lz - 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_side_reg <= s4_side_next;
            s4_sh_reg   <= s4_sh_next;
            for (int i = 0; i < 3; i++)
            begin
                s4_mag_reg[i] <= s3_mag_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------ S5
    logic             s5_vld_reg;
    v3alu_pkg::side_t s5_side_reg;
    v3alu_pkg::mag_t  s5_mag_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_side_reg <= s4_side_reg;
            for (int i = 0; i < 3; i++)
            begin
                s5_mag_reg[i] <= s4_mag_reg[i] << s4_sh_reg;
            end
        end
    end

    // ------------------------------------------------------------------ S6
    logic             s6_vld_reg;
    v3alu_pkg::side_t s6_side_reg;
    v3alu_pkg::mag_t  s6_mag_reg [3];
    logic [63:0]      s6_sq_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_side_reg <= s5_side_reg;
            for (int i = 0; i < 3; i++)
            begin
                s6_mag_reg[i] <= s5_mag_reg[i];
                s6_sq_reg[i]  <= 64'(s5_mag_reg[i]) * 64'(s5_mag_reg[i]);
            end
        end
    end

    // ---------------------------------------------------------- square root
    logic             sq_vld_reg  [0:SQ_STEPS];
    logic [63:0]      sq_v_reg    [0:SQ_STEPS];
    logic [63:0]      sq_r_reg    [0:SQ_STEPS];
    v3alu_pkg::mag_t  sq_mag_reg  [0:SQ_STEPS][3];
    v3alu_pkg::side_t sq_side_reg [0:SQ_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            sq_vld_reg[0] <= s6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_v_reg[0]    <= s6_sq_reg[0] + s6_sq_reg[1] + s6_sq_reg[2];
            sq_r_reg[0]    <= '0;
            sq_side_reg[0] <= s6_side_reg;
            for (int i = 0; i < 3; i++)
            begin
                sq_mag_reg[0][i] <= s6_mag_reg[i];
            end
        end
    end

    for (genvar k = 1; k <= SQ_STEPS; k++)
    begin : g_sqrt
        logic [63:0] sq_bit;
        logic [63:0] sq_trial;

        assign sq_bit   = 64'd1 << (64 - 2 * k);
        assign sq_trial = sq_r_reg[k-1] + sq_bit;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                sq_vld_reg[k] <= sq_vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (sq_v_reg[k-1] >= sq_trial)
                begin
                    sq_v_reg[k] <= sq_v_reg[k-1] - sq_trial;
                    sq_r_reg[k] <= (sq_r_reg[k-1] >> 1) + sq_bit;
                end
                else
                begin
                    sq_v_reg[k] <= sq_v_reg[k-1];
                    sq_r_reg[k] <= sq_r_reg[k-1] >> 1;
                end
                sq_side_reg[k] <= sq_side_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    sq_mag_reg[k][i] <= sq_mag_reg[k-1][i];
                end
            end
        end
    end

    // -------------------------------------------------------------- divider
    logic             dv_vld_reg  [0:DIV_STEPS];
    logic [NUM_W-1:0] dv_n_reg    [0:DIV_STEPS][3];
    logic [Q_W-1:0]   dv_q_reg    [0:DIV_STEPS][3];
    v3alu_pkg::mag_t  dv_m_reg    [0:DIV_STEPS];
    v3alu_pkg::side_t dv_side_reg [0:DIV_STEPS];

    v3alu_pkg::mag_t  dv_root;

    assign dv_root = sq_r_reg[SQ_STEPS][31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            dv_vld_reg[0] <= sq_vld_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_m_reg[0]    <= dv_root;
            dv_side_reg[0] <= sq_side_reg[SQ_STEPS];
            for (int i = 0; i < 3; i++)
            begin
                dv_n_reg[0][i] <= (NUM_W'(sq_mag_reg[SQ_STEPS][i]) << FRAC_BITS)
                                + NUM_W'(dv_root >> 1);
                dv_q_reg[0][i] <= '0;
            end
        end
    end

    for (genvar j = 1; j <= DIV_STEPS; j++)
    begin : g_div
        logic [NUM_W-1:0] dv_cmp;

        assign dv_cmp = NUM_W'(dv_m_reg[j-1]) << (DIV_STEPS - j);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                dv_vld_reg[j] <= dv_vld_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_m_reg[j]    <= dv_m_reg[j-1];
                dv_side_reg[j] <= dv_side_reg[j-1];
                for (int i = 0; i < 3; i++)
                begin
                    if (dv_n_reg[j-1][i] >= dv_cmp)
                    begin
                        dv_n_reg[j][i] <= dv_n_reg[j-1][i] - dv_cmp;
                        dv_q_reg[j][i] <= {dv_q_reg[j-1][i][Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_n_reg[j][i] <= dv_n_reg[j-1][i];
                        dv_q_reg[j][i] <= {dv_q_reg[j-1][i][Q_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // ---------------------------------------------------- unit vector scale
    logic               lt_vld_reg;
    v3alu_pkg::side_t   lt_side_reg;
    v3alu_pkg::fix_t    lt_n_reg [3];
    logic signed [63:0] lt_prod_reg [3];

    v3alu_pkg::fix_t    lt_n_next [3];

    always_comb
    begin
        v3alu_pkg::fix_t qf;
        for (int i = 0; i < 3; i++)
        begin
            qf = v3alu_pkg::fix_t'({{(32 - Q_W){1'b0}}, dv_q_reg[DIV_STEPS][i]});
            if (dv_side_reg[DIV_STEPS].zero)
            begin
                lt_n_next[i] = '0;
            end
            else if (dv_side_reg[DIV_STEPS].neg[i])
            begin
                lt_n_next[i] = -qf;
            end
            else
            begin
                lt_n_next[i] = qf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            lt_vld_reg <= dv_vld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lt_side_reg <= dv_side_reg[DIV_STEPS];
            for (int i = 0; i < 3; i++)
            begin
                lt_n_reg[i]    <= lt_n_next[i];
                lt_prod_reg[i] <= lt_n_next[i] * dv_side_reg[DIV_STEPS].factor;
            end
        end
    end

    // ------------------------------------------------------- output register
    v3alu_pkg::fix_t out_r_reg [3];
    logic            zero_length_reg;
    logic            saturated_reg;

    v3alu_pkg::fix_t out_r_next [3];
    logic            zero_length_next;
    logic            saturated_next;

    always_comb
    begin
        logic signed [63:0] t;
        t                = '0;
        zero_length_next = 1'b0;
        saturated_next   = lt_side_reg.sat;
        for (int i = 0; i < 3; i++)
        begin
            out_r_next[i] = lt_side_reg.res[i];
        end
        case (lt_side_reg.op)
            v3alu_pkg::OP_NORM:
            begin
                zero_length_next = lt_side_reg.zero;
                saturated_next   = 1'b0;
                for (int i = 0; i < 3; i++)
                begin
                    out_r_next[i] = lt_n_reg[i];
                end
            end
            v3alu_pkg::OP_NSCALE:
            begin
                zero_length_next = lt_side_reg.zero;
                saturated_next   = 1'b0;
                for (int i = 0; i < 3; i++)
                begin
                    t = (lt_prod_reg[i] + RND64) >>> FRAC_BITS;
                    if (t > SMAX64)
                    begin
                        out_r_next[i]  = FMAX;
                        saturated_next = 1'b1;
                    end
                    else if (t < SMIN64)
                    begin
                        out_r_next[i]  = FMIN;
                        saturated_next = 1'b1;
                    end
                    else
                    begin
                        out_r_next[i] = t[31:0];
                    end
                end
            end
            default:
            begin
                zero_length_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= lt_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zero_length_reg <= zero_length_next;
            saturated_reg   <= saturated_next;
            for (int i = 0; i < 3; i++)
            begin
                out_r_reg[i] <= out_r_next[i];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign rx          = out_r_reg[0];
    assign ry          = out_r_reg[1];
    assign rz          = out_r_reg[2];
    assign zero_length = zero_length_reg;
    assign saturated   = saturated_reg;

endmodule

### design/v3alu_chk.sv
// ----------------------------------------------------------------------------
// v3alu_chk
// Port-level checks of the vector ALU, bound to the top level.
// ----------------------------------------------------------------------------
module v3alu_chk (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input v3alu_pkg::fix_t rx,
    input v3alu_pkg::fix_t ry,
    input v3alu_pkg::fix_t rz,
    input logic            zero_length,
    input logic            saturated
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rx) && $stable(ry)
            && $stable(rz) && $stable(zero_length) && $stable(saturated))
        else $error("result changed while stalled");

    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("request stalled while result side drains");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request stalled with empty output");

    a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_length |-> rx == '0 && ry == '0 && rz == '0 && !saturated)
        else $error("zero-length result not a clean zero vector");

endmodule

bind vec3_fixed_point_alu v3alu_chk u_v3alu_chk (.*);

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the vector ALU: drives directed and random
// requests through every opcode, predicts each result in place and compares
// it field by field against the result channel, under varied idle and stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int FRAC = 16;
    localparam v3alu_pkg::fix_t FMAX = 32'sh7fffffff;
    localparam v3alu_pkg::fix_t FMIN = 32'sh80000000;
    localparam v3alu_pkg::fix_t ONE  = 32'sh00010000;

    typedef logic signed [79:0] wide_t;

    typedef struct {
        v3alu_pkg::op_t  op;
        v3alu_pkg::fix_t ax, ay, az, bx, by, bz, factor;
    } request_t;

    typedef struct {
        v3alu_pkg::fix_t rx, ry, rz;
        logic zl, sat;
    } vec_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    v3alu_pkg::op_t  op = v3alu_pkg::OP_ADD;
    v3alu_pkg::fix_t ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0, factor = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    v3alu_pkg::fix_t rx, ry, rz;
    logic zero_length, saturated;

    request_t    request_q[$];
    vec_result_t pending_results[$];
    int  snd_idle = 0;
    int  rcv_stall = 0;
    logic hold = 1'b0;
    logic took = 1'b0;
    int  errors = 0;

    vec3_fixed_point_alu dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
        .factor(factor), .out_valid(out_valid), .out_ready(out_ready),
        .rx(rx), .ry(ry), .rz(rz), .zero_length(zero_length),
        .saturated(saturated)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic wide_t round_q(input wide_t v);
        wide_t half;
        half = wide_t'(1) <<< (FRAC - 1);
        return (v + half) >>> FRAC;
    endfunction

    function automatic v3alu_pkg::fix_t clip(input wide_t v, inout logic sat);
        if (v > wide_t'(FMAX))
        begin
            sat = 1'b1;
            return FMAX;
        end
        if (v < wide_t'(FMIN))
        begin
            sat = 1'b1;
            return FMIN;
        end
        return v3alu_pkg::fix_t'(v[31:0]);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic unit_vec(input wide_t a[3], output wide_t n[3]);
        logic [63:0] mag[3];
        logic [63:0] mx, sum, m, q;
        int sh;
        mx = 0;
        sum = 0;
        sh = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = a[i] < 0 ? 64'(-a[i]) : 64'(a[i]);
            if (mag[i] > mx) mx = mag[i];
        end
        if (mx == 0)
        begin
            for (int i = 0; i < 3; i++) n[i] = 0;
            return 1'b1;
        end
        while (mx < (64'd1 << 30))
        begin
            mx = mx << 1;
            sh++;
        end
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = mag[i] << sh;
            sum = sum + mag[i] * mag[i];
        end
        m = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << FRAC) + (m >> 1)) / m;
            n[i] = a[i] < 0 ? -wide_t'(q) : wide_t'(q);
        end
        return 1'b0;
    endfunction

    function automatic vec_result_t vec_alu_predict(input request_t rq);
        wide_t a[3], b[3], n[3], r[3];
        wide_t f;
        logic sat, zl;
        vec_result_t res;
        a[0] = rq.ax; a[1] = rq.ay; a[2] = rq.az;
        b[0] = rq.bx; b[1] = rq.by; b[2] = rq.bz;
        f = rq.factor;
        sat = 1'b0;
        zl = 1'b0;
        case (rq.op)
            v3alu_pkg::OP_ADD:   for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
            v3alu_pkg::OP_SUB:   for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
            v3alu_pkg::OP_SCALE: for (int i = 0; i < 3; i++) r[i] = round_q(a[i] * f);
            v3alu_pkg::OP_CROSS:
            begin
                r[0] = round_q(a[1] * b[2] - a[2] * b[1]);
                r[1] = round_q(a[2] * b[0] - a[0] * b[2]);
                r[2] = round_q(a[0] * b[1] - a[1] * b[0]);
            end
            v3alu_pkg::OP_NORM:
            begin
                zl = unit_vec(a, n);
                for (int i = 0; i < 3; i++) r[i] = n[i];
            end
            v3alu_pkg::OP_NSCALE:
            begin
                zl = unit_vec(a, n);
                for (int i = 0; i < 3; i++) r[i] = round_q(n[i] * f);
            end
            default:  for (int i = 0; i < 3; i++) r[i] = a[i];
        endcase
        res.rx = clip(r[0], sat);
        res.ry = clip(r[1], sat);
        res.rz = clip(r[2], sat);
        res.zl = zl;
        res.sat = sat;
        return res;
    endfunction

    // drive requests and receiver readiness
    always @(negedge clk)
    begin
        request_t rq;
        took <= 1'b0;
        out_ready <= ($urandom_range(99) >= rcv_stall);
        if (!in_valid || took)
        begin
            if (rst_n && !hold && request_q.size() > 0 &&
                $urandom_range(99) >= snd_idle)
            begin
                rq = request_q.pop_front();
                op <= rq.op;
                ax <= rq.ax; ay <= rq.ay; az <= rq.az;
                bx <= rq.bx; by <= rq.by; bz <= rq.bz;
                factor <= rq.factor;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // predict accepted requests, check results
    always @(posedge clk)
    begin
        request_t rq;
        vec_result_t ex;
        if (in_valid && in_ready)
        begin
            rq.op = op;
            rq.ax = ax; rq.ay = ay; rq.az = az;
            rq.bx = bx; rq.by = by; rq.bz = bz;
            rq.factor = factor;
            pending_results.push_back(vec_alu_predict(rq));
            took <= 1'b1;
        end
        if (out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result expected none actual rx=%h ry=%h rz=%h",
                         $time, rx, ry, rz);
            end
            else
            begin
                ex = pending_results.pop_front();
                if (rx !== ex.rx || ry !== ex.ry || rz !== ex.rz ||
                    zero_length !== ex.zl || saturated !== ex.sat)
                begin
                    errors++;
                    $display({"%0t: mismatch expected %h %h %h zl=%b sat=%b",
                              " actual %h %h %h zl=%b sat=%b"},
                             $time, ex.rx, ex.ry, ex.rz, ex.zl, ex.sat,
                             rx, ry, rz, zero_length, saturated);
                end
            end
        end
    end

    function automatic v3alu_pkg::fix_t rand_fix();
        case ($urandom_range(7))
            0: return FMAX;
            1: return FMIN;
            2: return '0;
            3: return v3alu_pkg::fix_t'($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
            4: return ONE;
            5: return -ONE;
            default: return v3alu_pkg::fix_t'($urandom);
        endcase
    endfunction

    task automatic add_req(input v3alu_pkg::op_t o,
                           input v3alu_pkg::fix_t x0, y0, z0, x1, y1, z1, f);
        request_t rq;
        rq.op = o;
        rq.ax = x0; rq.ay = y0; rq.az = z0;
        rq.bx = x1; rq.by = y1; rq.bz = z1;
        rq.factor = f;
        request_q.push_back(rq);
    endtask

    task automatic add_random(input int count);
        v3alu_pkg::op_t o;
        v3alu_pkg::fix_t x, y, z;
        for (int i = 0; i < count; i++)
        begin
            o = ($urandom_range(15) == 0) ? v3alu_pkg::op_t'($urandom_range(6, 7))
                                           : v3alu_pkg::op_t'($urandom_range(0, 5));
            x = rand_fix();
            y = rand_fix();
            z = rand_fix();
            if ((o == v3alu_pkg::OP_NORM || o == v3alu_pkg::OP_NSCALE) &&
                $urandom_range(9) == 0)
            begin
                x = '0;
                y = '0;
                z = '0;
            end
            add_req(o, x, y, z, rand_fix(), rand_fix(), rand_fix(), rand_fix());
        end
    endtask

    task automatic drain();
        while (request_q.size() > 0 || in_valid || pending_results.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        add_req(v3alu_pkg::OP_ADD, FMAX, FMIN, ONE, FMAX, FMIN, -ONE, '0);
        add_req(v3alu_pkg::OP_SUB, FMIN, FMAX, '0, FMAX, FMIN, '0, '0);
        add_req(v3alu_pkg::OP_SUB, 32'sd5, -32'sd7, ONE, 32'sd2, 32'sd3, ONE, '0);
        add_req(v3alu_pkg::OP_SCALE, FMAX, FMIN, ONE, '0, '0, '0, FMAX);
        add_req(v3alu_pkg::OP_SCALE, FMIN, 32'sh8000, -32'sh8000, '0, '0, '0, 32'sd1);
        add_req(v3alu_pkg::OP_SCALE, ONE, -ONE, 32'sd3, '0, '0, '0, FMIN);
        add_req(v3alu_pkg::OP_CROSS, FMIN, FMAX, FMIN, FMAX, FMIN, FMAX, '0);
        add_req(v3alu_pkg::OP_CROSS, FMIN, FMIN, FMIN, FMIN, FMIN, FMIN, '0);
        add_req(v3alu_pkg::OP_CROSS, ONE, '0, '0, '0, ONE, '0, '0);
        add_req(v3alu_pkg::OP_NORM, '0, '0, '0, FMAX, FMAX, FMAX, '0);
        add_req(v3alu_pkg::OP_NORM, FMIN, '0, '0, '0, '0, '0, '0);
        add_req(v3alu_pkg::OP_NORM, 32'sd1, '0, '0, '0, '0, '0, '0);
        add_req(v3alu_pkg::OP_NORM, FMAX, FMAX, FMAX, '0, '0, '0, '0);
        add_req(v3alu_pkg::OP_NORM, 32'sd3, -32'sd4, '0, '0, '0, '0, '0);
        add_req(v3alu_pkg::OP_NORM, FMIN, FMIN, FMIN, '0, '0, '0, '0);
        add_req(v3alu_pkg::OP_NSCALE, '0, '0, '0, '0, '0, '0, FMAX);
        add_req(v3alu_pkg::OP_NSCALE, FMAX, '0, '0, '0, '0, '0, FMAX);
        add_req(v3alu_pkg::OP_NSCALE, -32'sd1, '0, '0, '0, '0, '0, FMIN);
        add_req(v3alu_pkg::OP_NSCALE, ONE, ONE, ONE, '0, '0, '0, ONE);
        add_req(v3alu_pkg::op_t'(6), FMAX, FMIN, ONE, 32'sd1, 32'sd2, 32'sd3, FMAX);
        add_req(v3alu_pkg::op_t'(7), FMIN, '0, -ONE, 32'sd1, 32'sd2, 32'sd3, FMIN);

        snd_idle = 0;  rcv_stall = 0;  add_random(200); drain();
        snd_idle = 55; rcv_stall = 0;  add_random(110);
        while (request_q.size() > 0) @(posedge clk);
        hold <= 1'b1;
        drain();
        hold <= 1'b0;
        add_random(100); drain();
        snd_idle = 0;  rcv_stall = 55; add_random(210); drain();
        snd_idle = 30; rcv_stall = 30; add_random(210); drain();
        repeat (120) @(posedge clk);

        if (errors == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
design/v3alu_pkg.sv
design/vec3_fixed_point_alu.sv
design/v3alu_chk.sv
verif/tb.sv
